/* src/assert_macros.svh */
// Assertion helpers for the controller RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside reset.
`define GTP_ASSERT(label, prop) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error("controller assertion failed");

// Checks that a condition never holds outside reset.
`define GTP_NEVER(label, cond) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) !(cond)) \
    else $error("controller forbidden condition seen");

`endif

/* src/gtp_pkg.sv */
package gtp_pkg;

  localparam int POS_W     = 16;
  localparam int ANG_W     = 16;
  localparam int VEL_W     = 16;
  localparam int CFG_W     = 15;
  localparam int CFG_IDX_W = 3;
  localparam int ERR_W     = POS_W + 1;
  localparam int XW_W      = 50;
  localparam int TH_W      = 34;
  localparam int NCORDIC   = 16;
  localparam int NORM_W    = 30;
  localparam int SQ_W      = 2 * NORM_W + 1;
  localparam int ROOT_W    = 31;
  localparam int ISQ_STEPS = 32;
  localparam int ISQ_W     = 63;
  localparam int QUO_W     = 16;
  localparam int NUM_W     = 47;
  localparam int MAG_PAD_W = 56;
  localparam int NGROUP    = MAG_PAD_W / 8;

  localparam logic [31:0] INV_GAIN_Q31 = 32'd1304065748;
  localparam logic [31:0] TWO_PI_Q29   = 32'd3373259426;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MODE   = 3'd0,
    CFG_TOL    = 3'd1,
    CFG_MAX_VX = 3'd2,
    CFG_MAX_VY = 3'd3,
    CFG_MAX_W  = 3'd4
  } cfg_idx_e;

  // Per-item side information that rides alongside the datapath.
  typedef struct packed {
    logic                     done;
    logic signed [VEL_W-1:0]  vw;
    logic signed [VEL_W-1:0]  vx0;
    logic signed [VEL_W-1:0]  vy0;
    logic                     nx;
    logic                     ny;
    logic                     zero;
    logic [NORM_W-1:0]        nax;
    logic [NORM_W-1:0]        nay;
  } gtp_side_t;

  function automatic logic [31:0] atan_turn(input int unsigned i);
    logic [31:0] r;
    case (i)
      0:  r = 32'h20000000;
      1:  r = 32'h12E4051E;
      2:  r = 32'h09FB385B;
      3:  r = 32'h051111D4;
      4:  r = 32'h028B0D43;
      5:  r = 32'h0145D7E1;
      6:  r = 32'h00A2F61E;
      7:  r = 32'h00517C55;
      8:  r = 32'h0028BE53;
      9:  r = 32'h00145F2F;
      10: r = 32'h000A2F98;
      11: r = 32'h000517CC;
      12: r = 32'h00028BE6;
      13: r = 32'h000145F3;
      14: r = 32'h0000A2FA;
      15: r = 32'h0000517D;
      16: r = 32'h000028BE;
      17: r = 32'h0000145F;
      18: r = 32'h00000A30;
      19: r = 32'h00000518;
      20: r = 32'h0000028C;
      21: r = 32'h00000146;
      22: r = 32'h000000A3;
      23: r = 32'h00000051;
      24: r = 32'h00000029;
      25: r = 32'h00000014;
      26: r = 32'h0000000A;
      27: r = 32'h00000005;
      28: r = 32'h00000003;
      29: r = 32'h00000001;
      30: r = 32'h00000001;
      default: r = 32'h00000000;
    endcase
    return r;
  endfunction

  function automatic logic signed [VEL_W-1:0] clamp_vel(input logic signed [19:0] v,
                                                        input logic [CFG_W-1:0] lim);
    logic signed [19:0] l;
    logic signed [19:0] r;
    l = $signed({5'b0, lim});
    if (v > l) begin
      r = l;
    end else if (v < -l) begin
      r = -l;
    end else begin
      r = v;
    end
    return r[VEL_W-1:0];
  endfunction

endpackage

/* src/gtp_if.sv */
interface gtp_pose_if;
  logic                    valid;
  logic                    ready;
  logic signed [15:0]      pose_x;
  logic signed [15:0]      pose_y;
  logic signed [15:0]      pose_heading;
  logic signed [15:0]      dest_x;
  logic signed [15:0]      dest_y;
  logic signed [15:0]      dest_heading;
  modport source (output valid, pose_x, pose_y, pose_heading, dest_x, dest_y,
                  dest_heading, input ready);
  modport sink (input valid, pose_x, pose_y, pose_heading, dest_x, dest_y,
                dest_heading, output ready);
endinterface

interface gtp_vel_if;
  logic               valid;
  logic               ready;
  logic               done_res;
  logic signed [15:0] vel_x;
  logic signed [15:0] vel_y;
  logic signed [15:0] vel_w;
  modport source (output valid, done_res, vel_x, vel_y, vel_w, input ready);
  modport sink (input valid, done_res, vel_x, vel_y, vel_w, output ready);
endinterface

interface gtp_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [14:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

/* src/gtp_cordic.sv */
module gtp_cordic import gtp_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   en_i,
  input  logic                   valid_i,
  input  logic signed [XW_W-1:0] x_i,
  input  logic signed [XW_W-1:0] y_i,
  input  logic signed [TH_W-1:0] t_i,
  input  gtp_side_t              side_i,
  output logic                   valid_o,
  output logic signed [XW_W-1:0] x_o,
  output logic signed [XW_W-1:0] y_o,
  output gtp_side_t              side_o
);

  logic                   vld_q  [0:NCORDIC];
  logic signed [XW_W-1:0] x_q    [0:NCORDIC];
  logic signed [XW_W-1:0] y_q    [0:NCORDIC];
  logic signed [TH_W-1:0] t_q    [0:NCORDIC];
  gtp_side_t              side_q [0:NCORDIC];

  assign vld_q[0]  = valid_i;
  assign x_q[0]    = x_i;
  assign y_q[0]    = y_i;
  assign t_q[0]    = t_i;
  assign side_q[0] = side_i;

  for (genvar i = 0; i < NCORDIC; i++) begin : g_stage
    logic signed [XW_W-1:0] x_d, y_d;
    logic signed [TH_W-1:0] t_d, a;

    always_comb begin
      a = $signed({2'b0, atan_turn(i)});
      if (!t_q[i][TH_W-1]) begin
        x_d = x_q[i] - (y_q[i] >>> i);
        y_d = y_q[i] + (x_q[i] >>> i);
        t_d = t_q[i] - a;
      end else begin
        x_d = x_q[i] + (y_q[i] >>> i);
        y_d = y_q[i] - (x_q[i] >>> i);
        t_d = t_q[i] + a;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[i+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[i+1] <= vld_q[i];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        x_q[i+1]    <= x_d;
        y_q[i+1]    <= y_d;
        t_q[i+1]    <= t_d;
        side_q[i+1] <= side_q[i];
      end
    end
  end

  assign valid_o = vld_q[NCORDIC];
  assign x_o     = x_q[NCORDIC];
  assign y_o     = y_q[NCORDIC];
  assign side_o  = side_q[NCORDIC];

endmodule

/* src/gtp_isqrt.sv */
module gtp_isqrt import gtp_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              en_i,
  input  logic              valid_i,
  input  logic [SQ_W-1:0]   sq_i,
  input  gtp_side_t         side_i,
  output logic              valid_o,
  output logic [ROOT_W-1:0] root_o,
  output gtp_side_t         side_o
);

  logic             vld_q  [0:ISQ_STEPS];
  logic [ISQ_W-1:0] s_q    [0:ISQ_STEPS];
  logic [ISQ_W-1:0] r_q    [0:ISQ_STEPS];
  gtp_side_t        side_q [0:ISQ_STEPS];

  assign vld_q[0]  = valid_i;
  assign s_q[0]    = ISQ_W'(sq_i);
  assign r_q[0]    = '0;
  assign side_q[0] = side_i;

  // One result bit per stage, trial bit 4^(31-k) walking down from the top.
  for (genvar k = 0; k < ISQ_STEPS; k++) begin : g_step
    localparam logic [ISQ_W-1:0] Bit = ISQ_W'(1) << (62 - 2 * k);
    logic [ISQ_W-1:0] trial, s_d, r_d;

    always_comb begin
      trial = r_q[k] + Bit;
      if (s_q[k] >= trial) begin
        s_d = s_q[k] - trial;
        r_d = (r_q[k] >> 1) + Bit;
      end else begin
        s_d = s_q[k];
        r_d = r_q[k] >> 1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k+1] <= 1'b0;
      end else if (en_i) begin
        vld_q[k+1] <= vld_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        s_q[k+1]    <= s_d;
        r_q[k+1]    <= r_d;
        side_q[k+1] <= side_q[k];
      end
    end
  end

  assign valid_o = vld_q[ISQ_STEPS];
  assign root_o  = r_q[ISQ_STEPS][ROOT_W-1:0];
  assign side_o  = side_q[ISQ_STEPS];

endmodule

/* src/go_to_point_velocity_controller.sv */
// Throughput: one beat per cycle; the whole pipeline advances whenever the
// output register is empty or its beat is being taken, so stalls cost no items.
// Depth is set by the 16 CORDIC stages, 32 square-root stages and 16 divider stages.
// Reset clears all valid bits and loads the register defaults: mode 0,
// tolerance 51, speed limits 2048, 2048 and 4096.
module go_to_point_velocity_controller import gtp_pkg::*; (
  input  logic      clk_i,
  input  logic      rst_ni,
  gtp_pose_if.sink  pose_i,
  gtp_vel_if.source vel_o,
  gtp_cfg_if.sink   cfg_i
);

`include "assert_macros.svh"

  logic             mode_q;
  logic [CFG_W-1:0] tol_q, max_vx_q, max_vy_q, max_w_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= 1'b0;
      tol_q    <= CFG_W'(51);
      max_vx_q <= CFG_W'(2048);
      max_vy_q <= CFG_W'(2048);
      max_w_q  <= CFG_W'(4096);
    end else if (cfg_i.valid) begin
      case (cfg_idx_e'(cfg_i.index))
        CFG_MODE:   mode_q   <= cfg_i.data[0];
        CFG_TOL:    tol_q    <= cfg_i.data;
        CFG_MAX_VX: max_vx_q <= cfg_i.data;
        CFG_MAX_VY: max_vy_q <= cfg_i.data;
        CFG_MAX_W:  max_w_q  <= cfg_i.data;
        default: ;
      endcase
    end
  end

  logic out_vld_q;
  logic adv;

  assign adv          = !out_vld_q || vel_o.ready;
  assign pose_i.ready = adv;

  // Stage 1: errors.
  logic                    s1_vld_q;
  logic signed [ERR_W-1:0] s1_ex_q, s1_ey_q;
  logic signed [ANG_W-1:0] s1_dh_q, s1_th_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else if (adv) begin
      s1_vld_q <= pose_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_ex_q <= ERR_W'(pose_i.dest_x) - ERR_W'(pose_i.pose_x);
      s1_ey_q <= ERR_W'(pose_i.dest_y) - ERR_W'(pose_i.pose_y);
      s1_dh_q <= pose_i.dest_heading - pose_i.pose_heading;
      s1_th_q <= -pose_i.pose_heading;
    end
  end

  // Stage 2: products.
  logic                    s2_vld_q, s2_small_q, s2_negw_q;
  logic [31:0]             s2_sqx_q, s2_sqy_q;
  logic [2*CFG_W-1:0]      s2_tol2_q;
  logic [48:0]             s2_ap_q;
  logic signed [XW_W-1:0]  s2_xw_q, s2_yw_q;
  logic signed [ANG_W-1:0] s2_th_q;
  logic signed [2*ERR_W-1:0] sqx, sqy;
  logic [ANG_W:0]          a16;

  always_comb begin
    sqx = s1_ex_q * s1_ex_q;
    sqy = s1_ey_q * s1_ey_q;
    a16 = s1_dh_q[ANG_W-1] ? (ANG_W+1)'(-$signed({s1_dh_q[ANG_W-1], s1_dh_q}))
                           : (ANG_W+1)'(s1_dh_q);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else if (adv) begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_sqx_q   <= sqx[31:0];
      s2_sqy_q   <= sqy[31:0];
      s2_small_q <= (s1_ex_q <= 17'sd32767) && (s1_ex_q >= -17'sd32767) &&
                    (s1_ey_q <= 17'sd32767) && (s1_ey_q >= -17'sd32767);
      s2_tol2_q  <= tol_q * tol_q;
      s2_ap_q    <= 49'(a16) * 49'(TWO_PI_Q29);
      s2_negw_q  <= s1_dh_q[ANG_W-1];
      s2_xw_q    <= s1_ex_q * $signed({1'b0, INV_GAIN_Q31});
      s2_yw_q    <= s1_ey_q * $signed({1'b0, INV_GAIN_Q31});
      s2_th_q    <= s1_th_q;
    end
  end

  // Stage 3: arrival test, angular command, quadrant fold.
  logic                   s3_vld_q;
  logic signed [XW_W-1:0] s3_xw_q, s3_yw_q;
  logic signed [TH_W-1:0] s3_t_q;
  gtp_side_t              s3_side_q;
  logic [32:0]            sqsum;
  logic [49:0]            wr;
  logic [CFG_W-1:0]       wm;
  logic                   fold;
  logic signed [TH_W-1:0] t34;
  gtp_side_t              s3_side_d;

  always_comb begin
    sqsum = 33'(s2_sqx_q) + 33'(s2_sqy_q);
    if (mode_q) begin
      wr = (50'(s2_ap_q) + (50'(1) << 34)) >> 35;
    end else begin
      wr = (50'(s2_ap_q) + (50'(1) << 33)) >> 34;
    end
    wm   = (wr > 50'(max_w_q)) ? max_w_q : wr[CFG_W-1:0];
    fold = (s2_th_q > 16'sd16384) || (s2_th_q < -16'sd16384);
    t34  = $signed({{(TH_W-ANG_W-16){s2_th_q[ANG_W-1]}}, s2_th_q, 16'b0});
    if (fold) begin
      t34 = (s2_th_q > 16'sd0) ? t34 - (TH_W'(1) << 31) : t34 + (TH_W'(1) << 31);
    end
    s3_side_d      = '0;
    s3_side_d.done = s2_small_q && (sqsum < 33'(s2_tol2_q));
    s3_side_d.vw   = s2_negw_q ? -$signed({1'b0, wm}) : $signed({1'b0, wm});
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else if (adv) begin
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s3_xw_q   <= fold ? -s2_xw_q : s2_xw_q;
      s3_yw_q   <= fold ? -s2_yw_q : s2_yw_q;
      s3_t_q    <= t34;
      s3_side_q <= s3_side_d;
    end
  end

  logic                   c_vld;
  logic signed [XW_W-1:0] c_x, c_y;
  gtp_side_t              c_side;

  gtp_cordic u_cordic (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (s3_vld_q),
    .x_i     (s3_xw_q),
    .y_i     (s3_yw_q),
    .t_i     (s3_t_q),
    .side_i  (s3_side_q),
    .valid_o (c_vld),
    .x_o     (c_x),
    .y_o     (c_y),
    .side_o  (c_side)
  );

  // Stage 4: proportional result and magnitudes.
  logic                   s4_vld_q;
  logic [XW_W-1:0]        s4_ax_q, s4_ay_q, s4_m_q;
  gtp_side_t              s4_side_q;
  logic signed [XW_W-1:0] rx, ry;
  logic [XW_W-1:0]        ax, ay;
  gtp_side_t              s4_side_d;

  always_comb begin
    rx = c_x + (XW_W'(1) << 30);
    ry = c_y + (XW_W'(1) << 30);
    ax = c_x[XW_W-1] ? XW_W'(-c_x) : XW_W'(c_x);
    ay = c_y[XW_W-1] ? XW_W'(-c_y) : XW_W'(c_y);
    s4_side_d      = c_side;
    s4_side_d.vx0  = clamp_vel($signed({rx[XW_W-1:31], 1'b0}), max_vx_q);
    s4_side_d.vy0  = clamp_vel($signed({ry[XW_W-1:31], 1'b0}), max_vy_q);
    s4_side_d.nx   = c_x[XW_W-1];
    s4_side_d.ny   = c_y[XW_W-1];
    s4_side_d.zero = (c_x == '0) && (c_y == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_vld_q <= 1'b0;
    end else if (adv) begin
      s4_vld_q <= c_vld;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s4_ax_q   <= ax;
      s4_ay_q   <= ay;
      s4_m_q    <= (ax > ay) ? ax : ay;
      s4_side_q <= s4_side_d;
    end
  end

  // Stage 5: leading one within each byte of the larger magnitude.
  logic                   s5_vld_q;
  logic [XW_W-1:0]        s5_ax_q, s5_ay_q;
  logic [NGROUP-1:0]      s5_gnz_q;
  logic [2:0]             s5_gidx_q [NGROUP];
  gtp_side_t              s5_side_q;
  logic [MAG_PAD_W-1:0]   mpad;
  logic [NGROUP-1:0]      gnz;
  logic [2:0]             gidx [NGROUP];

  always_comb begin
    mpad = MAG_PAD_W'(s4_m_q);
    for (int g = 0; g < NGROUP; g++) begin
      gnz[g]  = |mpad[8*g +: 8];
      gidx[g] = '0;
      for (int b = 0; b < 8; b++) begin
        if (mpad[8*g+b]) begin
          gidx[g] = 3'(b);
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s5_vld_q <= 1'b0;
    end else if (adv) begin
      s5_vld_q <= s4_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s5_ax_q   <= s4_ax_q;
      s5_ay_q   <= s4_ay_q;
      s5_gnz_q  <= gnz;
      s5_gidx_q <= gidx;
      s5_side_q <= s4_side_q;
    end
  end

  // Stage 6: position of the leading one.
  logic            s6_vld_q;
  logic [XW_W-1:0] s6_ax_q, s6_ay_q;
  logic [5:0]      s6_msb_q;
  gtp_side_t       s6_side_q;
  logic [5:0]      msb;

  always_comb begin
    msb = '0;
    for (int g = 0; g < NGROUP; g++) begin
      if (s5_gnz_q[g]) begin
        msb = {3'(g), s5_gidx_q[g]};
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s6_vld_q <= 1'b0;
    end else if (adv) begin
      s6_vld_q <= s5_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s6_ax_q   <= s5_ax_q;
      s6_ay_q   <= s5_ay_q;
      s6_msb_q  <= msb;
      s6_side_q <= s5_side_q;
    end
  end

  // Stage 7: bring the larger magnitude into [2^29, 2^30).
  logic            s7_vld_q;
  gtp_side_t       s7_side_q;
  logic [XW_W-1:0] nx_w, ny_w;
  gtp_side_t       s7_side_d;

  always_comb begin
    if (s6_msb_q >= 6'd29) begin
      nx_w = s6_ax_q >> (s6_msb_q - 6'd29);
      ny_w = s6_ay_q >> (s6_msb_q - 6'd29);
    end else begin
      nx_w = s6_ax_q << (6'd29 - s6_msb_q);
      ny_w = s6_ay_q << (6'd29 - s6_msb_q);
    end
    s7_side_d     = s6_side_q;
    s7_side_d.nax = nx_w[NORM_W-1:0];
    s7_side_d.nay = ny_w[NORM_W-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s7_vld_q <= 1'b0;
    end else if (adv) begin
      s7_vld_q <= s6_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s7_side_q <= s7_side_d;
    end
  end

  // Stage 8: squares. Stage 9: their sum.
  logic                s8_vld_q, s9_vld_q;
  logic [2*NORM_W-1:0] s8_sx_q, s8_sy_q;
  logic [SQ_W-1:0]     s9_sum_q;
  gtp_side_t           s8_side_q, s9_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s8_vld_q <= 1'b0;
      s9_vld_q <= 1'b0;
    end else if (adv) begin
      s8_vld_q <= s7_vld_q;
      s9_vld_q <= s8_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s8_sx_q   <= s7_side_q.nax * s7_side_q.nax;
      s8_sy_q   <= s7_side_q.nay * s7_side_q.nay;
      s8_side_q <= s7_side_q;
      s9_sum_q  <= SQ_W'(s8_sx_q) + SQ_W'(s8_sy_q);
      s9_side_q <= s8_side_q;
    end
  end

  logic              q_vld;
  logic [ROOT_W-1:0] q_root;
  gtp_side_t         q_side;

  gtp_isqrt u_isqrt (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (adv),
    .valid_i (s9_vld_q),
    .sq_i    (s9_sum_q),
    .side_i  (s9_side_q),
    .valid_o (q_vld),
    .root_o  (q_root),
    .side_o  (q_side)
  );

  // Stage 10: limit times magnitude. Stage 11: add half the norm for rounding.
  logic              s10_vld_q, s11_vld_q;
  logic [44:0]       s10_px_q, s10_py_q;
  logic [ROOT_W-1:0] s10_n_q, s11_n_q;
  logic [NUM_W-1:0]  s11_numx_q, s11_numy_q;
  gtp_side_t         s10_side_q, s11_side_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s10_vld_q <= 1'b0;
      s11_vld_q <= 1'b0;
    end else if (adv) begin
      s10_vld_q <= q_vld;
      s11_vld_q <= s10_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s10_px_q   <= max_vx_q * q_side.nax;
      s10_py_q   <= max_vy_q * q_side.nay;
      s10_n_q    <= q_root;
      s10_side_q <= q_side;
      s11_numx_q <= NUM_W'(s10_px_q) + NUM_W'(s10_n_q >> 1);
      s11_numy_q <= NUM_W'(s10_py_q) + NUM_W'(s10_n_q >> 1);
      s11_n_q    <= s10_n_q;
      s11_side_q <= s10_side_q;
    end
  end

  // Restoring division, one quotient bit per stage for both axes.
  logic              dv_vld_q  [0:QUO_W];
  logic [NUM_W-1:0]  dv_rx_q   [0:QUO_W];
  logic [NUM_W-1:0]  dv_ry_q   [0:QUO_W];
  logic [QUO_W-1:0]  dv_qx_q   [0:QUO_W];
  logic [QUO_W-1:0]  dv_qy_q   [0:QUO_W];
  logic [ROOT_W-1:0] dv_n_q    [0:QUO_W];
  gtp_side_t         dv_side_q [0:QUO_W];

  assign dv_vld_q[0]  = s11_vld_q;
  assign dv_rx_q[0]   = s11_numx_q;
  assign dv_ry_q[0]   = s11_numy_q;
  assign dv_qx_q[0]   = '0;
  assign dv_qy_q[0]   = '0;
  assign dv_n_q[0]    = s11_n_q;
  assign dv_side_q[0] = s11_side_q;

  for (genvar j = 0; j < QUO_W; j++) begin : g_div
    localparam int Sh = QUO_W - 1 - j;
    logic [NUM_W-1:0] dd, rx_d, ry_d;
    logic [QUO_W-1:0] qx_d, qy_d;

    always_comb begin
      dd   = NUM_W'(dv_n_q[j]) << Sh;
      rx_d = dv_rx_q[j];
      ry_d = dv_ry_q[j];
      qx_d = dv_qx_q[j];
      qy_d = dv_qy_q[j];
      if (dv_rx_q[j] >= dd) begin
        rx_d     = dv_rx_q[j] - dd;
        qx_d[Sh] = 1'b1;
      end
      if (dv_ry_q[j] >= dd) begin
        ry_d     = dv_ry_q[j] - dd;
        qy_d[Sh] = 1'b1;
      end
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_vld_q[j+1] <= 1'b0;
      end else if (adv) begin
        dv_vld_q[j+1] <= dv_vld_q[j];
      end
    end

    always_ff @(posedge clk_i) begin
      if (adv) begin
        dv_rx_q[j+1]   <= rx_d;
        dv_ry_q[j+1]   <= ry_d;
        dv_qx_q[j+1]   <= qx_d;
        dv_qy_q[j+1]   <= qy_d;
        dv_n_q[j+1]    <= dv_n_q[j];
        dv_side_q[j+1] <= dv_side_q[j];
      end
    end
  end

  // Output register.
  logic                    out_done_q;
  logic signed [VEL_W-1:0] out_vx_q, out_vy_q, out_vw_q;
  logic signed [VEL_W-1:0] vx_d, vy_d, vw_d;
  gtp_side_t               fs;
  logic [QUO_W-1:0]        fqx, fqy;

  always_comb begin
    fs  = dv_side_q[QUO_W];
    fqx = dv_qx_q[QUO_W];
    fqy = dv_qy_q[QUO_W];
    if (fs.done) begin
      vx_d = '0;
      vy_d = '0;
      vw_d = '0;
    end else begin
      vw_d = fs.vw;
      if (!mode_q) begin
        vx_d = fs.vx0;
        vy_d = fs.vy0;
      end else if (fs.zero) begin
        vx_d = '0;
        vy_d = '0;
      end else begin
        vx_d = fs.nx ? -$signed(fqx) : $signed(fqx);
        vy_d = fs.ny ? -$signed(fqy) : $signed(fqy);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (adv) begin
      out_vld_q <= dv_vld_q[QUO_W];
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_done_q <= fs.done;
      out_vx_q   <= vx_d;
      out_vy_q   <= vy_d;
      out_vw_q   <= vw_d;
    end
  end

  assign vel_o.valid    = out_vld_q;
  assign vel_o.done_res = out_done_q;
  assign vel_o.vel_x    = out_vx_q;
  assign vel_o.vel_y    = out_vy_q;
  assign vel_o.vel_w    = out_vw_q;

  `GTP_ASSERT(a_done_still, vel_o.valid && vel_o.done_res |-> vel_o.vel_x == 16'sd0 && vel_o.vel_y == 16'sd0 && vel_o.vel_w == 16'sd0)
  `GTP_NEVER(a_no_idle_block, !vel_o.valid && !pose_i.ready)
  `GTP_ASSERT(a_out_fill, adv && dv_vld_q[QUO_W] |=> vel_o.valid)

endmodule
